// ===== hdl/open_addressing_hash_insert_macros.svh =====
// Assertion helpers shared by the hash insert RTL.
`ifndef OPEN_ADDRESSING_HASH_INSERT_MACROS_SVH
`define OPEN_ADDRESSING_HASH_INSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define OAHI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("open_addressing_hash_insert: check failed");

// Next-cycle implication.
`define OAHI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("open_addressing_hash_insert: check failed");

`endif

// ===== hdl/oahi_pkg.sv =====
package oahi_pkg;

    localparam int KEY_W      = 32;
    localparam int CFG_SIZE_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int SLOT_W     = 8;
    localparam int COLL_W     = 9;
    localparam int STATUS_W   = 2;

    // remainder unit retires this many key bits per cycle
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYC    = KEY_W / MOD_STEP;
    localparam int MOD_CNT_W  = $clog2(MOD_CYC);

    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;

    localparam logic                  RST_PROBE_MODE = 1'b1;
    localparam logic [CFG_SIZE_W-1:0] RST_TABLE_SIZE = 9'd10;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_PRESENT  = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

endpackage

// ===== hdl/oahi_mod.sv =====
module oahi_mod #(
    parameter int SW = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [oahi_pkg::KEY_W-1:0]  i_key,
    input  logic [SW-1:0]               i_size,
    output logic                        o_done,
    output logic [SW-1:0]               o_rem
);

    logic                             r_busy;
    logic                             r_done;
    logic [oahi_pkg::MOD_CNT_W-1:0]   r_cnt;
    logic [oahi_pkg::KEY_W-1:0]       r_q;
    logic [SW-1:0]                    r_rem;
    logic [SW-1:0]                    r_div;
    logic [SW-1:0]                    n_rem;

    // restoring remainder, MOD_STEP bits per cycle, MSB first
    always_comb begin
        logic [SW:0]   t;
        logic [SW-1:0] rem_v;
        rem_v = r_rem;
        for (int k = 0; k < oahi_pkg::MOD_STEP; k++) begin
            t = {rem_v, r_q[oahi_pkg::KEY_W-1-k]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem_v = t[SW-1:0];
        end
        n_rem = rem_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == oahi_pkg::MOD_CNT_W'(oahi_pkg::MOD_CYC - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_key;
            r_rem <= '0;
            r_div <= i_size;
        end else if (r_busy) begin
            r_q   <= r_q << oahi_pkg::MOD_STEP;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/open_addressing_hash_insert.sv =====
// Steps from input transfer to o_out_valid: remainder of the key by the size in use, home load,
//   memory read, a compare for each probe taken (1 to size in use), result register.
// Throughput: one item at a time, next key taken once the last result is registered; probes
//   are pipelined on the slot memory read port, one probe per cycle after the first read.
// Reset: synchronous; the slot memory's min(TABLE_DEPTH, 511) entries are swept clear
//   while input stays stalled; configuration writes are taken throughout.
`include "open_addressing_hash_insert_macros.svh"

module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [oahi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [oahi_pkg::CFG_SIZE_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [oahi_pkg::KEY_W-1:0]        i_key,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [oahi_pkg::SLOT_W-1:0]       o_slot,
    output logic [oahi_pkg::COLL_W-1:0]       o_collisions,
    output logic [oahi_pkg::STATUS_W-1:0]     o_status
);

    // table_size cannot exceed its register range, so slots past that are unreachable
    localparam int SIZE_LIM = (1 << oahi_pkg::CFG_SIZE_W) - 1;
    localparam int MAXS     = (TABLE_DEPTH < SIZE_LIM) ? TABLE_DEPTH : SIZE_LIM;
    localparam int SW       = $clog2(MAXS + 1);
    localparam int PW       = $clog2(MAXS);
    localparam int MW       = oahi_pkg::KEY_W + 1;

    // entry = {valid, key}
    logic [MW-1:0]                   r_slot_mem [MAXS];
    logic [MW-1:0]                   r_rd;

    oahi_pkg::t_state                r_state, n_state;
    logic [PW-1:0]                   r_clr, n_clr;
    logic [SW-1:0]                   r_pos, n_pos;
    logic [SW-1:0]                   r_step, n_step;
    logic [SW-1:0]                   r_i, n_i;
    oahi_pkg::t_status               r_fin, n_fin;
    logic                            r_out_valid, n_out_valid;
    logic [oahi_pkg::SLOT_W-1:0]     r_out_slot;
    logic [oahi_pkg::COLL_W-1:0]     r_out_coll;
    oahi_pkg::t_status               r_out_status;

    logic                            r_cfg_mode;
    logic [oahi_pkg::CFG_SIZE_W-1:0] r_cfg_size;
    logic [SW-1:0]                   r_size;
    logic [oahi_pkg::KEY_W-1:0]      r_key;

    logic [SW-1:0]                   size_use;
    logic                            in_acc;
    logic                            out_free;
    logic                            div_done;
    logic [SW-1:0]                   div_rem;
    logic [SW:0]                     pos_sum;
    logic [SW-1:0]                   adv_pos;
    logic [SW:0]                     step_t0, step_t1;
    logic [SW-1:0]                   adv_step;
    logic                            rd_valid;
    logic [oahi_pkg::KEY_W-1:0]      rd_key;
    logic [PW-1:0]                   rd_addr;
    logic [PW-1:0]                   wr_addr;
    logic [MW-1:0]                   wr_data;
    logic                            wr_en;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != oahi_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= oahi_pkg::RST_PROBE_MODE;
            r_cfg_size <= oahi_pkg::RST_TABLE_SIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                oahi_pkg::CFG_PROBE_MODE: r_cfg_mode <= i_cfg_data[0];
                oahi_pkg::CFG_TABLE_SIZE: r_cfg_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_size == '0) begin
            size_use = SW'(1);
        end else if (r_cfg_size > oahi_pkg::CFG_SIZE_W'(MAXS)) begin
            size_use = SW'(MAXS);
        end else begin
            size_use = SW'(r_cfg_size);
        end
    end

    oahi_mod #(
        .SW (SW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_key   (i_key),
        .i_size  (size_use),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // next probe: position and quadratic step both kept reduced mod size
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_step};
        adv_pos = (pos_sum >= {1'b0, r_size}) ? SW'(pos_sum - {1'b0, r_size})
                                             : SW'(pos_sum);
        step_t0 = {1'b0, r_step} + (SW + 1)'(2);
        step_t1 = (step_t0 >= {1'b0, r_size}) ? step_t0 - {1'b0, r_size} : step_t0;
        adv_step = (step_t1 >= {1'b0, r_size}) ? SW'(step_t1 - {1'b0, r_size})
                                              : SW'(step_t1);
    end

    assign rd_valid = r_rd[MW-1];
    assign rd_key   = r_rd[oahi_pkg::KEY_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pos       = r_pos;
        n_step      = r_step;
        n_i         = r_i;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr     = r_pos[PW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_pos[PW-1:0];
        wr_data     = {1'b1, r_key};
        case (r_state)
            oahi_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                if (r_clr == PW'(MAXS - 1)) begin
                    n_state = oahi_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            oahi_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = oahi_pkg::ST_HASH;
                end
            end
            oahi_pkg::ST_HASH: begin
                if (div_done) begin
                    n_pos   = div_rem;
                    n_step  = (r_size == SW'(1)) ? '0 : SW'(1);
                    n_i     = '0;
                    n_state = oahi_pkg::ST_READ;
                end
            end
            oahi_pkg::ST_READ: begin
                n_state = oahi_pkg::ST_CHECK;
            end
            oahi_pkg::ST_CHECK: begin
                // read the following probe ahead; dropped if this one stops
                rd_addr = adv_pos[PW-1:0];
                if (!rd_valid) begin
                    wr_en   = 1'b1;
                    n_fin   = oahi_pkg::STAT_INSERTED;
                    n_state = oahi_pkg::ST_FINISH;
                end else if (rd_key == r_key) begin
                    n_fin   = oahi_pkg::STAT_PRESENT;
                    n_state = oahi_pkg::ST_FINISH;
                end else if (r_i + 1'b1 == r_size) begin
                    n_fin   = oahi_pkg::STAT_FULL;
                    n_pos   = '0;
                    n_i     = r_i + 1'b1;
                    n_state = oahi_pkg::ST_FINISH;
                end else begin
                    n_pos = adv_pos;
                    n_i   = r_i + 1'b1;
                    if (r_cfg_mode) begin
                        n_step = adv_step;
                    end
                end
            end
            oahi_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = oahi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = oahi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oahi_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_step <= n_step;
        r_i    <= n_i;
        r_fin  <= n_fin;
        if (in_acc) begin
            r_key  <= i_key;
            r_size <= size_use;
        end
        if (r_state == oahi_pkg::ST_FINISH && out_free) begin
            r_out_slot   <= oahi_pkg::SLOT_W'(r_pos);
            r_out_coll   <= oahi_pkg::COLL_W'(r_i);
            r_out_status <= r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_slot_mem[rd_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_out_slot;
    assign o_collisions = r_out_coll;
    assign o_status     = r_out_status;

    `OAHI_ASSERT_NXT(a_acc_to_hash, in_acc, r_state == oahi_pkg::ST_HASH)
    `OAHI_ASSERT_NOW(a_pos_in_range, r_state == oahi_pkg::ST_CHECK, r_pos < r_size)
    `OAHI_ASSERT_NOW(a_count_in_range, r_state == oahi_pkg::ST_CHECK, r_i < r_size)
    `OAHI_ASSERT_NOW(a_step_in_range, r_state == oahi_pkg::ST_CHECK, r_step < r_size)
    `OAHI_ASSERT_NOW(a_full_slot_zero, o_out_valid && (o_status == oahi_pkg::STAT_FULL), o_slot == '0)

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 256;
    localparam int          N_ITEMS     = 1400;
    localparam int          QUIET_AFTER = 1200;
    localparam int          DRAIN_WAIT  = 300;
    localparam int          LONG_HOLD   = 400;
    localparam longint      CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [oahi_pkg::SLOT_W-1:0] slot;
        logic [oahi_pkg::COLL_W-1:0] coll;
        oahi_pkg::t_status           status;
    } t_insert_outcome;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [oahi_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [oahi_pkg::CFG_SIZE_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [oahi_pkg::KEY_W-1:0]      i_key;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [oahi_pkg::SLOT_W-1:0]     o_slot;
    logic [oahi_pkg::COLL_W-1:0]     o_collisions;
    logic [oahi_pkg::STATUS_W-1:0]   o_status;

    // shadow of the hash table and its registers
    logic [oahi_pkg::KEY_W-1:0]      shadow_key [DEPTH];
    logic                            shadow_used[DEPTH];
    logic                            shadow_mode;
    logic [oahi_pkg::CFG_SIZE_W-1:0] shadow_size;

    logic [oahi_pkg::KEY_W-1:0]      key_q[$];
    t_insert_outcome                 insert_outcomes_q[$];
    int                              keys_fed;
    int                              keys_taken;
    int                              mismatches;
    longint                          cycle_count;

    int                              tx_idle_pct;
    int                              rx_idle_pct;
    int                              tx_gap;
    int                              rx_gap;
    int                              rx_hold_cnt;
    logic                            long_hold_req;
    logic                            quiet;
    logic                            key_taken_last;

    open_addressing_hash_insert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_slot       (o_slot),
        .o_collisions (o_collisions),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // probe the shadow table exactly as the block should, updating it on insert
    function automatic t_insert_outcome probe_insert(input logic [oahi_pkg::KEY_W-1:0] key);
        int unsigned     sz;
        int unsigned     home;
        int unsigned     pos;
        int unsigned     coll;
        t_insert_outcome res;
        sz = (shadow_size == 0) ? 1 : ((shadow_size > DEPTH) ? DEPTH : shadow_size);
        home = key % sz;
        coll = 0;
        for (int unsigned i = 0; i < sz; i++) begin
            pos = (home + (shadow_mode ? i * i : i)) % sz;
            if (!shadow_used[pos]) begin
                shadow_used[pos] = 1'b1;
                shadow_key[pos]  = key;
                res.slot   = pos[oahi_pkg::SLOT_W-1:0];
                res.coll   = coll[oahi_pkg::COLL_W-1:0];
                res.status = oahi_pkg::STAT_INSERTED;
                return res;
            end
            if (shadow_key[pos] == key) begin
                res.slot   = pos[oahi_pkg::SLOT_W-1:0];
                res.coll   = coll[oahi_pkg::COLL_W-1:0];
                res.status = oahi_pkg::STAT_PRESENT;
                return res;
            end
            coll++;
        end
        res.slot   = '0;
        res.coll   = coll[oahi_pkg::COLL_W-1:0];
        res.status = oahi_pkg::STAT_FULL;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: register writes, key transfers and result transfers
    always @(posedge i_clk) begin
        t_insert_outcome want;
        key_taken_last <= i_in_valid && !o_in_stall && i_rst_n;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    oahi_pkg::CFG_PROBE_MODE: shadow_mode = i_cfg_data[0];
                    oahi_pkg::CFG_TABLE_SIZE: shadow_size = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (insert_outcomes_q.size() == 0) begin
                    $display("%0t: unexpected result, actual slot %0d coll %0d status %0d",
                             $time, o_slot, o_collisions, o_status);
                    mismatches++;
                end else begin
                    want = insert_outcomes_q.pop_front();
                    check_field("slot", want.slot, o_slot);
                    check_field("collisions", want.coll, o_collisions);
                    check_field("status", want.status, o_status);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                insert_outcomes_q.push_back(probe_insert(i_key));
                keys_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // key driver
    always @(negedge i_clk) begin
        if (!i_in_valid || key_taken_last) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (key_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if ($urandom_range(0, 99) < tx_idle_pct) begin
                tx_gap = $urandom_range(1, 14) - 1;
                i_in_valid <= 1'b0;
            end else begin
                i_key      <= key_q.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // result stall driver
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            rx_hold_cnt   = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rx_gap = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [oahi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [oahi_pkg::CFG_SIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_table(input logic mode, input logic [oahi_pkg::CFG_SIZE_W-1:0] size);
        write_reg(oahi_pkg::CFG_PROBE_MODE, {{(oahi_pkg::CFG_SIZE_W-1){1'b0}}, mode});
        write_reg(oahi_pkg::CFG_TABLE_SIZE, size);
    endtask

    task automatic feed(input logic [oahi_pkg::KEY_W-1:0] key);
        key_q.push_back(key);
        keys_fed++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (keys_taken != keys_fed || insert_outcomes_q.size() != 0);
    endtask

    // one setting of the table, keys drawn mostly from a small pool so that
    // repeats, shared home slots and full tables come up often
    task automatic random_phase(input int n);
        logic [oahi_pkg::KEY_W-1:0]      pool[$];
        logic [oahi_pkg::CFG_SIZE_W-1:0] sz;
        int unsigned                     eff;
        int                              pool_n;
        case ($urandom_range(0, 19))
            0:       sz = '0;
            1:       sz = oahi_pkg::CFG_SIZE_W'($urandom_range(257, 511));
            2:       sz = oahi_pkg::CFG_SIZE_W'(DEPTH);
            3:       sz = oahi_pkg::CFG_SIZE_W'($urandom_range(17, 255));
            default: sz = oahi_pkg::CFG_SIZE_W'($urandom_range(1, 16));
        endcase
        eff = (sz == 0) ? 1 : ((sz > DEPTH) ? DEPTH : sz);
        set_table(($urandom_range(0, 1) == 1), sz);
        pool_n = ((eff < 16) ? eff : 16) + $urandom_range(1, 6);
        repeat (pool_n) begin
            case ($urandom_range(0, 3))
                0, 1: pool.push_back($urandom);
                2:    pool.push_back($urandom_range(0, 65535) * eff + $urandom_range(0, 3));
                default: pool.push_back($urandom_range(0, 300));
            endcase
        end
        repeat (n) begin
            if ($urandom_range(0, 3) != 0)
                feed(pool[$urandom_range(0, pool.size() - 1)]);
            else
                feed($urandom);
        end
    endtask

    initial begin
        int phase;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_key          = '0;
        i_out_stall    = 1'b0;
        key_taken_last = 1'b0;
        long_hold_req  = 1'b0;
        quiet          = 1'b0;
        tx_gap         = 0;
        rx_gap         = 0;
        rx_hold_cnt    = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        keys_fed       = 0;
        keys_taken     = 0;
        mismatches     = 0;
        cycle_count    = 0;
        shadow_mode    = oahi_pkg::RST_PROBE_MODE;
        shadow_size    = oahi_pkg::RST_TABLE_SIZE;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: quadratic over 10 slots, which reaches only 6 distinct
        // slots from home 0, so the 7th key on that home sees a full table
        feed(32'd0);
        feed(32'd10);
        feed(32'd20);
        feed(32'd30);
        feed(32'd40);
        feed(32'd50);
        feed(32'd60);
        feed(32'd10);
        feed(32'hFFFF_FFFF);
        feed(32'd7);
        wait_drained();

        // size 0 acts as a single slot
        write_reg(oahi_pkg::CFG_TABLE_SIZE, '0);
        feed(32'd3);
        feed(32'd0);
        wait_drained();

        // oversize clamps to the full depth; linear probe wraps past the top slot
        set_table(1'b0, 9'h1FF);
        feed(32'hFFFF_FFFF);
        feed(32'h0000_00FF);
        feed(32'hAAAA_AAAA);
        feed(32'h5555_5555);
        wait_drained();

        set_table(1'b1, 9'h100);
        feed(32'h0000_0100);
        feed(32'h8000_0000);
        wait_drained();

        set_table(1'b1, 9'd2);
        feed(32'd1);
        feed(32'd3);
        feed(32'd5);
        wait_drained();

        phase = 0;
        while (keys_fed < N_ITEMS) begin
            phase++;
            if (keys_fed >= QUIET_AFTER)
                quiet = 1'b1;
            tx_idle_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            rx_idle_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            // receiver holds off while keys keep coming, backing up the input
            if (phase == 2)
                long_hold_req = 1'b1;
            random_phase($urandom_range(20, 60));
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && insert_outcomes_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== open_addressing_hash_insert.f =====
+incdir+hdl
hdl/oahi_pkg.sv
hdl/oahi_mod.sv
hdl/open_addressing_hash_insert.sv
tb/sv/tb.sv
